>>> rtl/core/htc_pkg.sv
// Shared types, codes and defaults for the humidity and temperature conversion unit
`timescale 1ns / 1ps

package htc_pkg;

    // default number of fractional bits in the fixed-point coefficients
    localparam int COEF_FRAC_BITS_DEF = 16;

    // request payload
    typedef struct packed {
        logic        operation;
        logic [15:0] raw_word;
    } in_t;

    // result payload
    typedef struct packed {
        logic               kind;
        logic signed [11:0] reading;
        logic               saturated;
    } out_t;

    // datapath step codes
    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_SQ       = 4'd1,
        DP_A2       = 4'd2,
        DP_A1       = 4'd3,
        DP_LIN      = 4'd4,
        DP_Q1       = 4'd5,
        DP_MQ       = 4'd6,
        DP_D        = 4'd7,
        DP_RQ       = 4'd8,
        DP_HUM_OUT  = 4'd9,
        DP_TEMP_OUT = 4'd10
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/htc_ctrl.sv
// Sequencing state machine for the conversion unit
`timescale 1ns / 1ps

module htc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_operation,
    output logic             req_ready,
    output htc_pkg::cmd_t    cmd,
    input  htc_pkg::status_t status
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_SQ   = 11'b00000000010,
        ST_A2   = 11'b00000000100,
        ST_A1   = 11'b00000001000,
        ST_LIN  = 11'b00000010000,
        ST_Q1   = 11'b00000100000,
        ST_MQ   = 11'b00001000000,
        ST_D    = 11'b00010000000,
        ST_RQ   = 11'b00100000000,
        ST_HOUT = 11'b01000000000,
        ST_TOUT = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    // next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = htc_pkg::DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = req_operation ? ST_SQ : ST_TOUT;
                end
            end
            ST_SQ:
            begin
                cmd.op     = htc_pkg::DP_SQ;
                state_next = ST_A2;
            end
            ST_A2:
            begin
                cmd.op     = htc_pkg::DP_A2;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                cmd.op     = htc_pkg::DP_A1;
                state_next = ST_LIN;
            end
            ST_LIN:
            begin
                cmd.op     = htc_pkg::DP_LIN;
                state_next = ST_Q1;
            end
            ST_Q1:
            begin
                cmd.op     = htc_pkg::DP_Q1;
                state_next = ST_MQ;
            end
            ST_MQ:
            begin
                cmd.op     = htc_pkg::DP_MQ;
                state_next = ST_D;
            end
            ST_D:
            begin
                cmd.op     = htc_pkg::DP_D;
                state_next = ST_RQ;
            end
            ST_RQ:
            begin
                cmd.op     = htc_pkg::DP_RQ;
                state_next = ST_HOUT;
            end
            ST_HOUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = htc_pkg::DP_HUM_OUT;
                    state_next = ST_IDLE;
                end
            end
            ST_TOUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = htc_pkg::DP_TEMP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // a humidity request starts the multiply sequence right away
    a_hum_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation |=> state_reg == ST_SQ)
        else $error("humidity request did not start the sequence");

    // a result is only written when the output register can take it
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == htc_pkg::DP_HUM_OUT || cmd.op == htc_pkg::DP_TEMP_OUT)
        |-> status.out_free)
        else $error("result written over a pending result");
`endif

endmodule

>>> rtl/core/htc_datapath.sv
// Fixed-point datapath with one shared multiplier and the result register
`timescale 1ns / 1ps

module htc_datapath #(
    parameter int COEF_FRAC_BITS = htc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  htc_pkg::in_t      req,
    input  htc_pkg::cmd_t     cmd,
    output htc_pkg::status_t  status,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output htc_pkg::out_t     rsp
);

    localparam int F   = COEF_FRAC_BITS;
    // accumulator holds signed Q11.F values, from -2048 up to just under 2048
    localparam int LW  = F + 12;
    localparam int MQW = F + 3;
    localparam int AW  = (LW > 26) ? LW : 26;
    localparam int BW  = MQW;
    localparam int PW  = AW + BW;

    // coefficient magnitudes, rounded to nearest
    localparam longint C_A0 = ((64'sd47844 <<< F) + 64'sd5000) / 64'sd10000;
    localparam longint C_A1 = ((64'sd4008 <<< F) + 64'sd5000) / 64'sd10000;
    localparam longint C_A2 = ((64'sd393 <<< F) + 64'sd50000) / 64'sd100000;
    localparam longint C_Q0 = ((64'sd1973 <<< F) + 64'sd5000) / 64'sd10000;
    localparam longint C_Q1 = ((64'sd237 <<< F) + 64'sd50000) / 64'sd100000;

    localparam logic signed [LW-1:0]  COEF_A0 = LW'(-C_A0);
    localparam logic signed [BW-1:0]  COEF_A1 = BW'(C_A1);
    localparam logic signed [BW-1:0]  COEF_A2 = BW'(-C_A2);
    localparam logic signed [MQW-1:0] COEF_Q0 = MQW'(C_Q0);
    localparam logic signed [BW-1:0]  COEF_Q1 = BW'(C_Q1);

    localparam logic signed [PW-1:0] HALF_8 = PW'(64'sd1 <<< 7);
    localparam logic signed [PW-1:0] HALF_4 = PW'(64'sd1 <<< 3);
    localparam logic signed [PW-1:0] HALF_5 = PW'(64'sd1 <<< 4);
    localparam logic signed [PW-1:0] HALF_F = PW'(64'sd1 <<< (F - 1));
    localparam logic signed [LW:0]   HALF_OUT = (LW + 1)'(64'sd1 <<< (F - 1));
    localparam logic signed [LW:0]   BIAS_OUT = (LW + 1)'((64'sd1 <<< F) - 64'sd1);

    localparam logic [15:0] LAST_TEMP_RESET = 16'd800;

    logic [15:0]              raw_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [LW-1:0]     acc_reg;
    logic signed [LW-1:0]     acc_next;
    logic signed [MQW-1:0]    mq_reg;
    logic signed [15:0]       last_temp_reg;
    logic                     out_valid_reg;
    htc_pkg::out_t            out_reg;
    htc_pkg::out_t            out_next;

    logic signed [13:0]       hs;
    logic signed [16:0]       d;
    logic signed [LW-1:0]     hq;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;
    logic                     mul_en;
    logic signed [PW-1:0]     r8;
    logic signed [PW-1:0]     r4;
    logic signed [PW-1:0]     r5;
    logic signed [PW-1:0]     rf;
    logic signed [LW:0]       hsum;
    logic signed [LW:0]       hval;
    logic signed [15:0]       t;
    logic signed [16:0]       tsum;
    logic signed [16:0]       tval;
    logic signed [12:0]       val13;

    // saturate a 13-bit value to the 12-bit output range
    function automatic logic [12:0] clamp12(input logic signed [12:0] v);
        logic [12:0] r;
        if (v > 13'sd2047)
        begin
            r = {1'b1, 12'h7FF};
        end
        else if (v < -13'sd2048)
        begin
            r = {1'b1, 12'h800};
        end
        else
        begin
            r = {1'b0, v[11:0]};
        end
        return r;
    endfunction

    // fields of the captured word
    assign hs = $signed({2'b00, raw_reg[15:4]}) - 14'sd384;
    assign d  = 17'(last_temp_reg) - 17'sd960;
    assign hq = LW'(hs) <<< (F - 4);
    assign t  = $signed({2'b00, raw_reg[15:2]}) - 16'sd1600;

    // multiplier operand selection
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            htc_pkg::DP_SQ:
            begin
                mul_a = AW'(hs);
                mul_b = BW'(hs);
            end
            htc_pkg::DP_A2:
            begin
                mul_a = $signed(prod_reg[AW-1:0]);
                mul_b = COEF_A2;
            end
            htc_pkg::DP_A1:
            begin
                mul_a = AW'(hs);
                mul_b = COEF_A1;
            end
            htc_pkg::DP_Q1:
            begin
                mul_a = AW'(acc_reg);
                mul_b = COEF_Q1;
            end
            htc_pkg::DP_D:
            begin
                mul_a = AW'(d);
                mul_b = mq_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half up of the registered product
    assign r8 = (prod_reg + HALF_8) >>> 8;
    assign r4 = (prod_reg + HALF_4) >>> 4;
    assign r5 = (prod_reg + HALF_5) >>> 5;
    assign rf = (prod_reg + HALF_F) >>> F;

    // final rounding, truncating toward zero
    assign hsum = (LW + 1)'(acc_reg) + HALF_OUT;
    assign hval = (hsum + (hsum[LW] ? BIAS_OUT : (LW + 1)'(0))) >>> F;
    assign tsum = 17'(t) + 17'sd16;
    assign tval = (tsum + (tsum[16] ? 17'sd31 : 17'sd0)) >>> 5;

    // accumulator and result selection
    always_comb
    begin
        acc_next = acc_reg;
        val13    = 13'(tval);
        out_next = out_reg;
        case (cmd.op)
            htc_pkg::DP_A1:
            begin
                acc_next = LW'(r8);
            end
            htc_pkg::DP_LIN:
            begin
                acc_next = hq - (acc_reg + LW'(r4) + COEF_A0);
            end
            htc_pkg::DP_RQ:
            begin
                acc_next = acc_reg + LW'(r5);
            end
            htc_pkg::DP_HUM_OUT:
            begin
                val13         = 13'(hval);
                out_next.kind = 1'b1;
                {out_next.saturated, out_next.reading} = clamp12(val13);
            end
            htc_pkg::DP_TEMP_OUT:
            begin
                out_next.kind = 1'b0;
                {out_next.saturated, out_next.reading} = clamp12(val13);
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg <= req.raw_word;
        end
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.op == htc_pkg::DP_MQ)
        begin
            mq_reg <= MQW'(rf) + COEF_Q0;
        end
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    // last temperature and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg <= LAST_TEMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == htc_pkg::DP_TEMP_OUT)
            begin
                last_temp_reg <= t;
            end
            if (cmd.op == htc_pkg::DP_HUM_OUT || cmd.op == htc_pkg::DP_TEMP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || rsp_ready;
    assign rsp_valid       = out_valid_reg;
    assign rsp             = out_reg;

`ifndef SYNTH
    // the stored temperature only moves on a temperature result
    a_temp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_temp_reg) |-> $past(cmd.op) == htc_pkg::DP_TEMP_OUT)
        else $error("last temperature changed outside a temperature result");

    // a temperature result shows up tagged as temperature
    a_temp_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == htc_pkg::DP_TEMP_OUT |=> rsp_valid && !rsp.kind)
        else $error("temperature result missing or mistagged");

    // a humidity result shows up tagged as humidity
    a_hum_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == htc_pkg::DP_HUM_OUT |=> rsp_valid && rsp.kind)
        else $error("humidity result missing or mistagged");
`endif

endmodule

>>> rtl/core/humidity_temperature_conversion_unit.sv
// Top level of the humidity and temperature conversion unit
`timescale 1ns / 1ps

// Converts raw sensor words to rounded degrees Celsius or percent relative
// humidity. A temperature request (operation 0) uses the top 14 bits of
// raw_word, updates the stored last temperature and presents its result
// after the output write. A humidity request (operation 1) uses the top 12
// bits, applies the quadratic linearization and the temperature correction
// from the last temperature (25 degC after reset), and presents its result
// after eight datapath steps (five products run in turn through one shared
// multiplier plus three accumulate and rounding steps) and the output write.
// After either, the next request can be taken once the controller is back
// in idle. One request is worked on at a time; a finished result waits in
// the output register while the next request is accepted, and the next
// result write stalls until that register is free. Values outside
// -2048..2047 are clamped and flagged in saturated.
module humidity_temperature_conversion_unit #(
    parameter int COEF_FRAC_BITS = htc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  htc_pkg::in_t  req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output htc_pkg::out_t rsp
);

    htc_pkg::cmd_t    cmd;
    htc_pkg::status_t status;

    // sequencer
    htc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req.operation),
        .req_ready     (req_ready),
        .cmd           (cmd),
        .status        (status)
    );

    // arithmetic and result register
    htc_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
